FILE: src/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Types, microcode table and saturation helpers for the clamped
// proportional-resonant controller.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int PROD_W         = 2 * DATA_WIDTH;
    localparam int ACC_W          = DATA_WIDTH + 2;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_STEPS      = 8;
    localparam int STEP_W         = $clog2(NUM_STEPS);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic [STEP_W-1:0]            step_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A        = 3'd0,
        REG_COEF_B        = 3'd1,
        REG_COEF_C        = 3'd2,
        REG_GAIN_RES      = 3'd3,
        REG_GAIN_PROP     = 3'd4,
        REG_UPPER_LIMIT   = 3'd5,
        REG_LOWER_LIMIT   = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OPA_KR,
        OPA_B,
        OPA_C,
        OPA_KA,
        OPA_KP
    } opa_sel_t;

    typedef enum logic [2:0] {
        OPB_A,
        OPB_RP1,
        OPB_RP2,
        OPB_D,
        OPB_E
    } opb_sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LD_D,
        ACT_LD_KA,
        ACT_ACC_LD,
        ACT_ACC_ADD,
        ACT_TERM,
        ACT_OUT_SUM,
        ACT_OUT_TERM
    } act_t;

    typedef enum logic {
        JMP_NONE,
        JMP_TERM
    } jmp_t;

    typedef struct packed {
        opa_sel_t opa;
        opb_sel_t opb;
        act_t     act;
        jmp_t     jmp;
        step_t    target;
        logic     last;
    } ctrl_t;

    // Product register lags the multiply by one step, so each action consumes
    // the product issued in the step before it.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = '{opa: OPA_KR, opb: OPB_A, act: ACT_NONE, jmp: JMP_NONE,
               target: '0, last: 1'b0};
        case (step)
            3'd0: begin
                cw.opa = OPA_KR;  cw.opb = OPB_A;   cw.act = ACT_LD_D;
            end
            3'd1: begin
                cw.opa = OPA_B;   cw.opb = OPB_RP1; cw.act = ACT_LD_KA;
            end
            3'd2: begin
                cw.opa = OPA_C;   cw.opb = OPB_RP2; cw.act = ACT_ACC_LD;
            end
            3'd3: begin
                cw.opa = OPA_KA;  cw.opb = OPB_D;   cw.act = ACT_ACC_ADD;
            end
            3'd4: begin
                cw.opa = OPA_KP;  cw.opb = OPB_E;   cw.act = ACT_ACC_ADD;
            end
            3'd5: begin
                cw.act    = ACT_TERM;
                cw.jmp    = JMP_TERM;
                cw.target = step_t'(7);
            end
            3'd6: begin
                cw.act  = ACT_OUT_SUM;
                cw.last = 1'b1;
            end
            3'd7: begin
                cw.act  = ACT_OUT_TERM;
                cw.last = 1'b1;
            end
            default: begin
                cw.act  = ACT_NONE;
                cw.last = 1'b1;
            end
        endcase
        return cw;
    endfunction

    // Floor shift of the Q-scaled product, saturated to the data width.
    function automatic data_t scale_sat(input prod_t p);
        prod_t sh;
        sh = p >>> COEF_FRAC_BITS;
        if ((&sh[PROD_W-1:DATA_WIDTH-1]) || !(|sh[PROD_W-1:DATA_WIDTH-1]))
            return sh[DATA_WIDTH-1:0];
        return sh[PROD_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    function automatic data_t acc_sat(input acc_t a);
        if ((&a[ACC_W-1:DATA_WIDTH-1]) || !(|a[ACC_W-1:DATA_WIDTH-1]))
            return a[DATA_WIDTH-1:0];
        return a[ACC_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

endpackage

FILE: src/pr_controller_clamped.sv
// ----------------------------------------------------------------------------
// pr_controller_clamped
// Proportional-resonant controller with clamped term and output, run by a
// microcoded sequencer over one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Each word takes the accepting cycle plus seven microprogram steps on the
// single multiplier and accumulator; in_stall holds off the next word until
// the last step, and an output step waits while the output register is stalled.
// A pending result may wait in the output register while the next word runs.
// Reset (async, active low) clears histories, control, and loads register
// defaults: coefficients zero, limits at full scale.
module pr_controller_clamped
    import prc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_WIDTH-1:0] error_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_WIDTH-1:0] drive_value,
    output logic                 saturated
);

    data_t coef_a_reg, coef_b_reg, coef_c_reg, gain_res_reg, gain_prop_reg;
    data_t upper_reg, lower_reg;

    data_t err_prev1_reg, err_prev2_reg, res_prev1_reg, res_prev2_reg;

    data_t e_reg, d_reg, ka_reg, r_reg;
    prod_t prod_reg;
    acc_t  acc_reg;

    logic  busy_reg;
    step_t step_reg;
    logic  out_valid_reg;
    data_t drive_reg;
    logic  saturated_reg;

    ctrl_t cw;
    data_t opa_val, opb_val;
    prod_t prod_next;
    data_t scaled;
    acc_t  diff;
    data_t r_sum, r_next, o_sum, drive_next;
    logic  r_hit, flag_next;
    logic  advance, in_accept, out_accept;
    step_t step_next;

    assign cw         = ucode(step_reg);
    assign in_stall   = busy_reg;
    assign in_accept  = in_valid && !busy_reg;
    assign out_accept = out_valid_reg && !out_stall;
    // hold on an output step until the output register frees up
    assign advance    = busy_reg && !(cw.last && out_valid_reg && out_stall);

    always_comb
    begin
        case (cw.opa)
            OPA_KR:  opa_val = gain_res_reg;
            OPA_B:   opa_val = coef_b_reg;
            OPA_C:   opa_val = coef_c_reg;
            OPA_KA:  opa_val = ka_reg;
            OPA_KP:  opa_val = gain_prop_reg;
            default: opa_val = gain_res_reg;
        endcase
        case (cw.opb)
            OPB_A:   opb_val = coef_a_reg;
            OPB_RP1: opb_val = res_prev1_reg;
            OPB_RP2: opb_val = res_prev2_reg;
            OPB_D:   opb_val = d_reg;
            OPB_E:   opb_val = e_reg;
            default: opb_val = coef_a_reg;
        endcase
    end

    assign prod_next = opa_val * opb_val;
    assign scaled    = scale_sat(prod_reg);
    assign diff      = ACC_W'(e_reg) - ACC_W'(err_prev2_reg);

    // resonant term clamp: upper test first, touching a limit counts
    always_comb
    begin
        r_sum = acc_sat(acc_reg);
        if (r_sum >= upper_reg)
        begin
            r_next = upper_reg;
            r_hit  = 1'b1;
        end
        else if (r_sum <= lower_reg)
        begin
            r_next = lower_reg;
            r_hit  = 1'b1;
        end
        else
        begin
            r_next = r_sum;
            r_hit  = 1'b0;
        end
    end

    always_comb
    begin
        o_sum = acc_sat(acc_reg + ACC_W'(r_reg));
        if (cw.act == ACT_OUT_TERM)
        begin
            drive_next = r_reg;
            flag_next  = 1'b1;
        end
        else if (o_sum >= lower_reg && o_sum <= upper_reg)
        begin
            drive_next = o_sum;
            flag_next  = 1'b0;
        end
        else if (o_sum > upper_reg)
        begin
            drive_next = upper_reg;
            flag_next  = 1'b1;
        end
        else
        begin
            drive_next = lower_reg;
            flag_next  = 1'b1;
        end
    end

    always_comb
    begin
        if (cw.jmp == JMP_TERM && r_hit)
            step_next = cw.target;
        else
            step_next = step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
            coef_c_reg    <= '0;
            gain_res_reg  <= '0;
            gain_prop_reg <= '0;
            upper_reg     <= DATA_MAX;
            lower_reg     <= DATA_MIN;
            err_prev1_reg <= '0;
            err_prev2_reg <= '0;
            res_prev1_reg <= '0;
            res_prev2_reg <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_COEF_A:      coef_a_reg    <= cfg_data;
                    REG_COEF_B:      coef_b_reg    <= cfg_data;
                    REG_COEF_C:      coef_c_reg    <= cfg_data;
                    REG_GAIN_RES:    gain_res_reg  <= cfg_data;
                    REG_GAIN_PROP:   gain_prop_reg <= cfg_data;
                    REG_UPPER_LIMIT: upper_reg     <= cfg_data;
                    REG_LOWER_LIMIT: lower_reg     <= cfg_data;
                    default:         ;
                endcase
            end

            if (out_accept)
                out_valid_reg <= 1'b0;

            if (in_accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (advance)
            begin
                step_reg <= step_next;
                if (cw.last)
                    busy_reg <= 1'b0;
                if (cw.act == ACT_TERM)
                begin
                    // shift histories with the clamped term
                    res_prev2_reg <= res_prev1_reg;
                    res_prev1_reg <= r_next;
                    err_prev2_reg <= err_prev1_reg;
                    err_prev1_reg <= e_reg;
                end
                if (cw.act == ACT_OUT_SUM || cw.act == ACT_OUT_TERM)
                    out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
            e_reg <= error_sample;
        if (advance)
        begin
            prod_reg <= prod_next;
            case (cw.act)
                ACT_LD_D:    d_reg   <= acc_sat(diff);
                ACT_LD_KA:   ka_reg  <= scaled;
                ACT_ACC_LD:  acc_reg <= ACC_W'(scaled);
                ACT_ACC_ADD: acc_reg <= acc_reg + ACC_W'(scaled);
                ACT_TERM:
                begin
                    r_reg   <= r_next;
                    acc_reg <= ACC_W'(scaled);
                end
                ACT_OUT_SUM, ACT_OUT_TERM:
                begin
                    drive_reg     <= drive_next;
                    saturated_reg <= flag_next;
                end
                default: ;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;
    assign saturated   = saturated_reg;

endmodule

FILE: verif/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Watches the register port and both word channels of the clamped PR
// controller. It keeps its own copy of the registers and the error and
// resonant histories, predicts drive value and saturation flag for every
// accepted error word, and compares each accepted result field by field
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module prc_checker
    import prc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] error_sample,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [DATA_WIDTH-1:0] drive_value,
    input  logic                  saturated,
    output int                    backlog,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI    = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint SAT_LO    = -SAT_HI - 1;

    typedef struct packed {
        data_t drive;
        logic  sat;
    } drive_word_t;

    data_t coef_a, coef_b, coef_c, gain_res, gain_prop, upper_lim, lower_lim;
    data_t err_hist1, err_hist2, res_hist1, res_hist2;

    drive_word_t expected_q[$];
    int          pending_cnt;
    int          fail_cnt = 0;

    assign backlog    = pending_cnt;
    assign mismatches = fail_cnt;

    function automatic longint clamp_data(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // Exact product, floor shift by the coefficient fraction, saturate.
    function automatic longint scaled_product(input longint x, input longint y);
        longint p;
        p = (x * y) >>> COEF_FRAC_BITS;
        return clamp_data(p);
    endfunction

    // Run one control step on the model state and return the drive word.
    function automatic drive_word_t next_drive(input data_t sample);
        longint      e, ka, d, r, o, up, lo;
        drive_word_t w;
        e  = sample;
        up = upper_lim;
        lo = lower_lim;
        ka = scaled_product(gain_res, coef_a);
        d  = clamp_data(e - longint'(err_hist2));
        r  = clamp_data(scaled_product(ka, d)
                        + scaled_product(coef_b, res_hist1)
                        + scaled_product(coef_c, res_hist2));
        w.sat = 1'b1;
        // upper test first, so under crossed limits a term at or above the upper limit lands on it
        if (r >= up)
            r = up;
        else if (r <= lo)
            r = lo;
        else
            w.sat = 1'b0;

        res_hist2 = res_hist1;
        res_hist1 = data_t'(r);
        err_hist2 = err_hist1;
        err_hist1 = sample;

        if (w.sat)
            w.drive = data_t'(r);
        else
        begin
            o = clamp_data(scaled_product(gain_prop, e) + r);
            if (o >= lo && o <= up)
                w.drive = data_t'(o);
            else if (o > up)
            begin
                w.drive = data_t'(up);
                w.sat   = 1'b1;
            end
            else
            begin
                w.drive = data_t'(lo);
                w.sat   = 1'b1;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t prc_checker: %s", $realtime, msg);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            coef_a    = '0;
            coef_b    = '0;
            coef_c    = '0;
            gain_res  = '0;
            gain_prop = '0;
            upper_lim = DATA_MAX;
            lower_lim = DATA_MIN;
            err_hist1 = '0;
            err_hist2 = '0;
            res_hist1 = '0;
            res_hist2 = '0;
            expected_q.delete();
            pending_cnt <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_COEF_A:      coef_a    = cfg_data;
                    REG_COEF_B:      coef_b    = cfg_data;
                    REG_COEF_C:      coef_c    = cfg_data;
                    REG_GAIN_RES:    gain_res  = cfg_data;
                    REG_GAIN_PROP:   gain_prop = cfg_data;
                    REG_UPPER_LIMIT: upper_lim = cfg_data;
                    REG_LOWER_LIMIT: lower_lim = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %h/%b with no word pending",
                                              drive_value, saturated));
                else
                begin
                    want = expected_q.pop_front();
                    if (drive_value !== want.drive)
                        report_mismatch($sformatf("drive_value %h, expected %h",
                                                  drive_value, want.drive));
                    if (saturated !== want.sat)
                        report_mismatch($sformatf("saturated %b, expected %b",
                                                  saturated, want.sat));
                end
            end

            if (in_valid && !in_stall)
                expected_q.push_back(next_drive(error_sample));

            pending_cnt <= expected_q.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the clamped PR controller: register writes while idle, a directed
// run over the field extremes, limit hits and crossed limits, then random
// phases of error words under changing settings and idling. Checking is done
// by prc_checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import prc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int    ONE_Q16       = 65536;
    localparam data_t COEF_ONE      = 32'sh1000_0000;
    localparam int    NUM_PHASES    = 12;
    localparam int    SETTLE_CYCLES = 16;
    localparam int    MAX_GAP       = 40;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wen      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [DATA_WIDTH-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic [DATA_WIDTH-1:0] error_sample = '0;
    logic                  out_stall    = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [DATA_WIDTH-1:0] drive_value;
    logic                  saturated;
    int                    backlog;
    int                    mismatches;

    int send_pct  = 0;
    int stall_pct = 0;

    always #6 clk = ~clk;

    pr_controller_clamped i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_value  (drive_value),
        .saturated    (saturated)
    );

    prc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_value  (drive_value),
        .saturated    (saturated),
        .backlog      (backlog),
        .mismatches   (mismatches)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin send_pct = 54; stall_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  stall_pct = 54; end
            IDLE_BOTH: begin send_pct = 14; stall_pct = 14; end
            default:   begin send_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input data_t value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Called at a clock edge; returns at the edge that takes the word.
    task automatic send_sample(input data_t value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        error_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic data_t pick_error();
        int span;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       return DATA_MAX;
                    1:       return DATA_MIN;
                    2:       return '0;
                    3:       return data_t'(1);
                    default: return data_t'(-1);
                endcase
            end
            1, 2:
                return data_t'($urandom);
            default:
            begin
                span = 1 << $urandom_range(22, 6);
                return data_t'(int'($urandom_range(2 * span)) - span);
            end
        endcase
    endfunction

    task automatic load_settings(input int phase);
        data_t ca, cb, cc, kr, kp, up, lo, tmp;
        if (phase == 0)
        begin
            ca = DATA_MAX; cb = DATA_MAX; cc = DATA_MAX; kr = DATA_MAX; kp = DATA_MAX;
            up = DATA_MAX;
            lo = DATA_MIN;
        end
        else if (phase == 1)
        begin
            ca = DATA_MIN; cb = DATA_MIN; cc = DATA_MIN; kr = DATA_MIN; kp = DATA_MIN;
            up = DATA_MIN;
            lo = DATA_MAX;
        end
        else if (phase % 3 == 0)
        begin
            ca = $urandom; cb = $urandom; cc = $urandom; kr = $urandom; kp = $urandom;
            up = $urandom;
            lo = $urandom;
        end
        else
        begin
            // lightly damped resonator: b near 2cos(wT), c near -1
            kr = data_t'($urandom_range(1 << 29));
            ca = data_t'($urandom_range(1 << 24));
            cb = data_t'($urandom_range(536870911, 483183820));
            cc = data_t'(-int'($urandom_range(268435456, 263066746)));
            kp = data_t'($urandom_range(1 << 29));
            if ($urandom_range(1))
                kp = -kp;
            up = data_t'($urandom_range(1 << 26, 1 << 16));
            lo = data_t'(-int'($urandom_range(1 << 26, 1 << 16)));
            if ($urandom_range(7) == 0)
            begin
                tmp = up;
                up  = lo;
                lo  = tmp;
            end
        end
        write_reg(REG_COEF_A, ca);
        write_reg(REG_COEF_B, cb);
        write_reg(REG_COEF_C, cc);
        write_reg(REG_GAIN_RES, kr);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_UPPER_LIMIT, up);
        write_reg(REG_LOWER_LIMIT, lo);
    endtask

    initial
    begin
        int n_items;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(IDLE_NONE);
        @(posedge clk);

        // reset settings: zero gains, full-scale limits
        write_reg(REG_UNUSED, data_t'($urandom));
        send_sample(DATA_MAX);
        send_sample(DATA_MIN);
        send_sample('0);
        send_sample(data_t'(1));
        send_sample(data_t'(-1));
        settle();

        // proportional path only: output on and past both limits
        write_reg(REG_GAIN_PROP, COEF_ONE);
        write_reg(REG_UPPER_LIMIT, data_t'(100 * ONE_Q16));
        write_reg(REG_LOWER_LIMIT, data_t'(-100 * ONE_Q16));
        send_sample(data_t'(100 * ONE_Q16));
        send_sample(data_t'(101 * ONE_Q16));
        send_sample(data_t'(-100 * ONE_Q16));
        send_sample(data_t'(-101 * ONE_Q16));
        send_sample(DATA_MAX);
        send_sample(DATA_MIN);
        settle();

        // resonant term equal to the upper, then the lower limit
        write_reg(REG_GAIN_PROP, '0);
        write_reg(REG_GAIN_RES, COEF_ONE);
        write_reg(REG_COEF_A, COEF_ONE);
        write_reg(REG_UPPER_LIMIT, data_t'(5 * ONE_Q16));
        write_reg(REG_LOWER_LIMIT, data_t'(-5 * ONE_Q16));
        send_sample('0);
        send_sample('0);
        send_sample(data_t'(5 * ONE_Q16));
        send_sample('0);
        send_sample('0);
        send_sample(data_t'(4 * ONE_Q16));
        settle();

        // crossed limits
        write_reg(REG_UPPER_LIMIT, data_t'(-ONE_Q16));
        write_reg(REG_LOWER_LIMIT, data_t'(ONE_Q16));
        send_sample('0);
        send_sample(data_t'(3 * ONE_Q16));
        send_sample(data_t'(-3 * ONE_Q16));
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            load_settings(p);
            set_idling(idle_mode_t'(p % 4));
            n_items = (p < 2) ? 40 : 117;
            for (int i = 0; i < n_items; i++)
                send_sample(pick_error());
            settle();
            set_idling(IDLE_NONE);
        end

        if (mismatches == 0 && backlog == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/prc_pkg.sv
src/pr_controller_clamped.sv
verif/prc_checker.sv
verif/tb_top.sv
